/* rtl/stok_pkg.sv */
`default_nettype none
package stok_pkg;

  // Field widths of one result token
  localparam int KIND_BITS = 5;
  localparam int TOK_BITS  = 16;

  // Results one input byte can cause at most
  localparam int SLOTS     = 3;
  localparam int CNT_BITS  = 2;

  // Defaults for the top-level parameters
  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // One token as it leaves the block (kind in the low bits when packed)
  typedef struct packed {
    logic [TOK_BITS-1:0]  length;
    logic [TOK_BITS-1:0]  start;
    logic [KIND_BITS-1:0] kind;
  } token_t;

  // All tokens caused by one byte, in order, slot 0 first
  typedef struct packed {
    logic [CNT_BITS-1:0] cnt;
    token_t [SLOTS-1:0]  slot;
  } bundle_t;

  // Queue control from the front end: push request and the full flag
  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

endpackage
`default_nettype wire

/* rtl/stok_front.sv */
`default_nettype none
module stok_front import stok_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output queue_ctl_t      q_ctl,
  output bundle_t         q_data
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_BANG,
    MODE_ASSIGN,
    MODE_DRAINED
  } mode_t;

  localparam logic [KIND_BITS-1:0] K_BANG    = 5'd12;
  localparam logic [KIND_BITS-1:0] K_NOTEQ   = 5'd13;
  localparam logic [KIND_BITS-1:0] K_ASSIGN  = 5'd14;
  localparam logic [KIND_BITS-1:0] K_EQ      = 5'd15;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd16;
  localparam logic [KIND_BITS-1:0] K_INT     = 5'd17;
  localparam logic [KIND_BITS-1:0] K_FLOAT   = 5'd18;
  localparam logic [KIND_BITS-1:0] K_ILLEGAL = 5'd19;
  localparam logic [KIND_BITS-1:0] K_EOF     = 5'd20;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int NUM_PUNCT = 12;
  localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
    8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h2C,
    8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3E
  };

  localparam logic [1:0] DOTS_MAX = 2'd2;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] run_start_r, run_start_nxt;
  logic [OFFSET_BITS-1:0] run_length_r, run_length_nxt;
  logic [1:0]             dot_count_r, dot_count_nxt;
  logic [OFFSET_BITS-1:0] byte_offset_r, byte_offset_nxt;

  logic                   is_alpha, is_numeral, is_dot, is_space;
  logic                   punct_hit;
  logic [KIND_BITS-1:0]   punct_kind;
  logic [OFFSET_BITS-1:0] len_inc, offset_inc;
  logic                   v0, v1, v2;
  token_t                 tok0, tok1, tok2;
  logic                   accept;

  function automatic logic is_run(mode_t m);
    return (m == MODE_IDENT) || (m == MODE_NUMBER) || (m == MODE_BANG) ||
           (m == MODE_ASSIGN);
  endfunction

  // Token for a pending run when it is closed
  function automatic token_t close_run(mode_t m, logic [OFFSET_BITS-1:0] st,
                                       logic [OFFSET_BITS-1:0] len, logic [1:0] dots);
    token_t t;
    t.start  = TOK_BITS'(st);
    t.length = TOK_BITS'(len);
    unique case (m)
      MODE_IDENT:  t.kind = K_IDENT;
      MODE_NUMBER: t.kind = (dots == 2'd0) ? K_INT : ((dots == 2'd1) ? K_FLOAT : K_ILLEGAL);
      MODE_BANG: begin
        t.kind   = K_BANG;
        t.length = TOK_BITS'(1);
      end
      MODE_ASSIGN: begin
        t.kind   = K_ASSIGN;
        t.length = TOK_BITS'(1);
      end
      default:     t.kind = K_EOF;
    endcase
    return t;
  endfunction

  // Classify the byte
  assign is_alpha   = ((in_char >= 8'h61) && (in_char <= 8'h7A)) ||
                      ((in_char >= 8'h41) && (in_char <= 8'h5A)) || (in_char == CH_UNDER);
  assign is_numeral = (in_char >= 8'h30) && (in_char <= 8'h39);
  assign is_dot     = (in_char == CH_DOT);
  assign is_space   = (in_char == CH_SPACE) || (in_char == CH_TAB) ||
                      (in_char == CH_LF) || (in_char == CH_CR);

  always_comb begin
    punct_hit  = 1'b0;
    punct_kind = '0;
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (in_char == PUNCT_CHARS[i]) begin
        punct_hit  = 1'b1;
        punct_kind = KIND_BITS'(i);
      end
    end
  end

  // Saturating run length, wrapping offset
  assign len_inc    = (run_length_r == '1) ? run_length_r : run_length_r + 1'b1;
  assign offset_inc = byte_offset_r + 1'b1;

  // Scan step: state update and up to three tokens
  always_comb begin
    mode_nxt        = mode_r;
    run_start_nxt   = run_start_r;
    run_length_nxt  = run_length_r;
    dot_count_nxt   = dot_count_r;
    byte_offset_nxt = offset_inc;
    v0   = 1'b0;
    v1   = 1'b0;
    v2   = 1'b0;
    tok0 = '0;
    tok1 = '0;
    tok2 = '0;

    priority if (mode_r == MODE_DRAINED) begin
      mode_nxt = MODE_DRAINED;
    end else if ((mode_r == MODE_IDENT) && is_alpha) begin
      run_length_nxt = len_inc;
    end else if ((mode_r == MODE_NUMBER) && (is_numeral || is_dot)) begin
      run_length_nxt = len_inc;
      if (is_dot && (dot_count_r != DOTS_MAX)) begin
        dot_count_nxt = dot_count_r + 2'd1;
      end
    end else if (((mode_r == MODE_BANG) || (mode_r == MODE_ASSIGN)) &&
                 (in_char == CH_EQUAL)) begin
      v0          = 1'b1;
      tok0.kind   = (mode_r == MODE_BANG) ? K_NOTEQ : K_EQ;
      tok0.start  = TOK_BITS'(run_start_r);
      tok0.length = TOK_BITS'(2);
      mode_nxt    = MODE_IDLE;
    end else begin
      // close the pending run, then start on this byte
      if (is_run(mode_r)) begin
        v0   = 1'b1;
        tok0 = close_run(mode_r, run_start_r, run_length_r, dot_count_r);
      end
      mode_nxt = MODE_IDLE;
      priority if (is_space) begin
        v1 = 1'b0;
      end else if (punct_hit) begin
        v1          = 1'b1;
        tok1.kind   = punct_kind;
        tok1.start  = TOK_BITS'(byte_offset_r);
        tok1.length = TOK_BITS'(1);
      end else if ((in_char == CH_BANG) || (in_char == CH_EQUAL)) begin
        mode_nxt       = (in_char == CH_BANG) ? MODE_BANG : MODE_ASSIGN;
        run_start_nxt  = byte_offset_r;
        run_length_nxt = OFFSET_BITS'(1);
      end else if (is_alpha || is_numeral) begin
        mode_nxt       = is_numeral ? MODE_NUMBER : MODE_IDENT;
        run_start_nxt  = byte_offset_r;
        run_length_nxt = OFFSET_BITS'(1);
        dot_count_nxt  = 2'd0;
      end else if (in_char == CH_NUL) begin
        v1          = 1'b1;
        tok1.kind   = K_EOF;
        tok1.start  = TOK_BITS'(byte_offset_r);
        tok1.length = '0;
        mode_nxt    = MODE_DRAINED;
      end else begin
        v1          = 1'b1;
        tok1.kind   = K_ILLEGAL;
        tok1.start  = TOK_BITS'(byte_offset_r);
        tok1.length = TOK_BITS'(1);
      end
    end

    // End marker: unless drained, flush what is left and add eof; return to reset state
    if (in_last) begin
      if (mode_nxt != MODE_DRAINED) begin
        if (is_run(mode_nxt)) begin
          v1   = 1'b1;
          tok1 = close_run(mode_nxt, run_start_nxt, run_length_nxt, dot_count_nxt);
        end
        v2          = 1'b1;
        tok2.kind   = K_EOF;
        tok2.start  = TOK_BITS'(offset_inc);
        tok2.length = '0;
      end
      mode_nxt        = MODE_IDLE;
      run_start_nxt   = '0;
      run_length_nxt  = '0;
      dot_count_nxt   = 2'd0;
      byte_offset_nxt = '0;
    end
  end

  // Pack the valid tokens from slot 0 up
  always_comb begin
    q_data.cnt     = CNT_BITS'({1'b0, v0} + {1'b0, v1} + {1'b0, v2});
    q_data.slot[0] = v0 ? tok0 : (v1 ? tok1 : tok2);
    q_data.slot[1] = (v0 && v1) ? tok1 : tok2;
    q_data.slot[2] = tok2;
  end

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign q_ctl.push = accept && (v0 || v1 || v2);
  assign q_ctl.full = q_full;

  // Hold scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      run_start_r   <= '0;
      run_length_r  <= '0;
      dot_count_r   <= 2'd0;
      byte_offset_r <= '0;
    end else if (accept) begin
      mode_r        <= mode_nxt;
      run_start_r   <= run_start_nxt;
      run_length_r  <= run_length_nxt;
      dot_count_r   <= dot_count_nxt;
      byte_offset_r <= byte_offset_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/stok_queue.sv */
`default_nettype none
module stok_queue import stok_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire queue_ctl_t ctl,
  input  wire bundle_t    wr_data,
  output logic            full,
  input  wire logic       pop,
  output bundle_t         head,
  output logic            head_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  bundle_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = ctl.push && !ctl.full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Store bundles
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/stok_back.sv */
`default_nettype none
module stok_back import stok_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire bundle_t     head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,
  output logic             out_tlast
);

  logic [CNT_BITS-1:0] sub_r;
  logic                out_valid_r;
  token_t              out_tok_r;
  logic                out_last_r;
  logic                load;
  logic                slot_last;

  assign load      = head_valid && (!out_valid_r || out_tready);
  assign slot_last = (sub_r == (head.cnt - 1'b1));
  assign pop       = load && slot_last;

  // Walk the head bundle one token per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sub_r       <= slot_last ? '0 : sub_r + 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= head.slot[sub_r];
      out_last_r <= slot_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_tok_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

/* rtl/source_byte_tokenizer.sv */
// Streaming tokenizer for source text.
// Input stream: one source byte per transfer on in_tdata[7:0]; in_tlast marks
// the last byte of a text. A zero byte also ends the text: the pending token
// and an eof token come out, and later bytes are dropped until in_tlast.
// Output stream: one token per transfer with kind, start offset and length;
// out_tlast is set on the last token caused by one input byte.
// Throughput: one byte per cycle, limited only by the output, which moves
// one token per cycle. A byte can cause up to three tokens; they leave one
// after another while input keeps flowing into a queue of QUEUE_DEPTH
// token groups between the scanner and the output stage.
// Path: a byte's transfer writes its token group into the queue, and the
// output register then loads the first token once it is free.
// Stall: while out_tready is low the output register holds; the queue fills,
// and in_tready drops once it is full. No token is lost.
// Reset (rst_n low, synchronous): scan state returns to idle, the byte offset
// to zero, and the queue and output register empty. After every in_tlast the
// scanner also returns to this state, so the next byte has offset zero.
`default_nettype none
module source_byte_tokenizer import stok_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [4:0] token_kind, [20:5] token_start,
                                       // [36:21] token_length, [39:37] zero
  output logic             out_tlast   // last_token
);

  queue_ctl_t q_ctl;
  bundle_t    q_wr;
  bundle_t    q_head;
  logic       q_full;
  logic       q_head_valid;
  logic       q_pop;

  stok_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .q_ctl    (q_ctl),
    .q_data   (q_wr)
  );

  stok_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (q_ctl),
    .wr_data    (q_wr),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  stok_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top import stok_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 295;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 20;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [TOK_BITS-1:0] LEN_ZERO = '0;
  localparam logic [TOK_BITS-1:0] LEN_ONE  = TOK_BITS'(1);
  localparam logic [TOK_BITS-1:0] LEN_TWO  = TOK_BITS'(2);

  typedef enum logic [KIND_BITS-1:0] {
    TK_LPAREN = 0, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_SEMI, TK_COMMA,
    TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_LT, TK_GT,
    TK_BANG, TK_NOTEQ, TK_ASSIGN, TK_EQ, TK_IDENT, TK_INT, TK_FLOAT,
    TK_ILLEGAL, TK_EOF
  } tok_kind_e;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_BANG, SCAN_ASSIGN, SCAN_DRAINED
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e           kind;
    logic [TOK_BITS-1:0] start;
    logic [TOK_BITS-1:0] len;
    logic                last;
  } token_rec_t;

  // One line of the directed script: a byte, and optionally its known token
  typedef struct packed {
    logic [7:0] chr;
    logic       eot;
    logic       has_tok;
    token_rec_t tok;
  } lex_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [39:0] out_tdata;  // [4:0] token_kind, [20:5] token_start,
                           // [36:21] token_length, [39:37] zero
  logic       out_tlast;   // last_token

  // Lexer state mirrored by the scoreboard
  scan_mode_e          scan_mode = SCAN_IDLE;
  logic [TOK_BITS-1:0] run_start = '0;
  logic [TOK_BITS-1:0] run_len = '0;
  logic [TOK_BITS-1:0] byte_ofs = '0;
  logic [1:0]          dot_cnt = '0;

  token_rec_t step_toks[$];
  token_rec_t expected_tokens[$];
  logic [7:0] text_bytes[$];
  bit         no_idle = 1'b0;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  source_byte_tokenizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit letter_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [TOK_BITS-1:0] sat_inc(logic [TOK_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic emit(tok_kind_e k, logic [TOK_BITS-1:0] s, logic [TOK_BITS-1:0] l);
    token_rec_t t;
    t.kind = k;
    t.start = s;
    t.len = l;
    t.last = 1'b0;
    step_toks.push_back(t);
  endtask

  // Close the pending run, if any
  task automatic flush_run();
    case (scan_mode)
      SCAN_IDENT: emit(TK_IDENT, run_start, run_len);
      SCAN_NUMBER: begin
        if (dot_cnt == 0) emit(TK_INT, run_start, run_len);
        else if (dot_cnt == 1) emit(TK_FLOAT, run_start, run_len);
        else emit(TK_ILLEGAL, run_start, run_len);
      end
      SCAN_BANG: emit(TK_BANG, run_start, LEN_ONE);
      SCAN_ASSIGN: emit(TK_ASSIGN, run_start, LEN_ONE);
      default: ;
    endcase
    scan_mode = SCAN_IDLE;
  endtask

  // Work out the tokens one byte causes; they land in step_toks
  task automatic lex_step(logic [7:0] c, logic eot);
    token_rec_t t;
    step_toks.delete();
    if (scan_mode == SCAN_DRAINED) begin
      // drop bytes until the end marker
    end else if (scan_mode == SCAN_IDENT && letter_char(c)) begin
      run_len = sat_inc(run_len);
    end else if (scan_mode == SCAN_NUMBER && (digit_char(c) || c == ".")) begin
      run_len = sat_inc(run_len);
      if (c == "." && dot_cnt < 2) dot_cnt = dot_cnt + 1'b1;
    end else if ((scan_mode == SCAN_BANG || scan_mode == SCAN_ASSIGN) && c == "=") begin
      emit(scan_mode == SCAN_BANG ? TK_NOTEQ : TK_EQ, run_start, LEN_TWO);
      scan_mode = SCAN_IDLE;
    end else begin
      flush_run();
      case (c)
        " ", CH_TAB, CH_LF, CH_CR: ;
        "(": emit(TK_LPAREN, byte_ofs, LEN_ONE);
        ")": emit(TK_RPAREN, byte_ofs, LEN_ONE);
        "{": emit(TK_LBRACE, byte_ofs, LEN_ONE);
        "}": emit(TK_RBRACE, byte_ofs, LEN_ONE);
        ";": emit(TK_SEMI, byte_ofs, LEN_ONE);
        ",": emit(TK_COMMA, byte_ofs, LEN_ONE);
        "+": emit(TK_PLUS, byte_ofs, LEN_ONE);
        "-": emit(TK_MINUS, byte_ofs, LEN_ONE);
        "*": emit(TK_STAR, byte_ofs, LEN_ONE);
        "/": emit(TK_SLASH, byte_ofs, LEN_ONE);
        "<": emit(TK_LT, byte_ofs, LEN_ONE);
        ">": emit(TK_GT, byte_ofs, LEN_ONE);
        "!", "=": begin
          scan_mode = (c == "!") ? SCAN_BANG : SCAN_ASSIGN;
          run_start = byte_ofs;
          run_len = LEN_ONE;
        end
        CH_NUL: begin
          emit(TK_EOF, byte_ofs, LEN_ZERO);
          scan_mode = SCAN_DRAINED;
        end
        default: begin
          if (letter_char(c) || digit_char(c)) begin
            scan_mode = digit_char(c) ? SCAN_NUMBER : SCAN_IDENT;
            run_start = byte_ofs;
            run_len = LEN_ONE;
            dot_cnt = '0;
          end else begin
            emit(TK_ILLEGAL, byte_ofs, LEN_ONE);
          end
        end
      endcase
    end

    // End marker: unless drained, flush and add eof; start a fresh text at offset zero
    if (eot) begin
      if (scan_mode != SCAN_DRAINED) begin
        flush_run();
        emit(TK_EOF, byte_ofs + 1'b1, LEN_ZERO);
      end
      scan_mode = SCAN_IDLE;
      run_start = '0;
      run_len = '0;
      dot_cnt = '0;
      byte_ofs = '0;
    end else begin
      byte_ofs = byte_ofs + 1'b1;
    end

    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
  endtask

  function automatic lex_row_t scan_only(logic [7:0] c, logic eot);
    lex_row_t r;
    r = '0;
    r.chr = c;
    r.eot = eot;
    return r;
  endfunction

  function automatic lex_row_t scan_tok(logic [7:0] c, tok_kind_e k, int s, int l);
    lex_row_t r;
    r = '0;
    r.chr = c;
    r.has_tok = 1'b1;
    r.tok.kind = k;
    r.tok.start = TOK_BITS'(s);
    r.tok.len = TOK_BITS'(l);
    r.tok.last = 1'b1;
    return r;
  endfunction

  // Present one byte after a random gap and hold it until the transfer
  task automatic feed_byte(logic [7:0] c, logic eot, logic has_tok, token_rec_t tok);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_step(c, eot);
    if (has_tok) begin
      expected_tokens.push_back(tok);
    end else begin
      foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
    end
  endtask

  // Hold the input idle until every expected token has come out
  task automatic drain_tokens();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // Build one random text: mostly well-formed lexemes, some noise
  task automatic compose_text();
    int n;
    logic [7:0] d;
    string puncts;
    puncts = "(){};,+-*/<>";
    text_bytes.delete();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          repeat ($urandom_range(1, 6)) begin
            n = $urandom_range(0, 52);
            if (n == 52) text_bytes.push_back("_");
            else if (n < 26) text_bytes.push_back("a" + n[7:0]);
            else text_bytes.push_back("A" + n[7:0] - 8'd26);
          end
        end
        3, 4: begin
          d = 8'($urandom_range(0, 9));
          text_bytes.push_back("0" + d);
          repeat ($urandom_range(0, 4)) begin
            d = 8'($urandom_range(0, 9));
            text_bytes.push_back("0" + d);
          end
          repeat ($urandom_range(0, 3)) begin
            text_bytes.push_back(".");
            if ($urandom_range(0, 1)) begin
              d = 8'($urandom_range(0, 9));
              text_bytes.push_back("0" + d);
            end
          end
        end
        5, 6: text_bytes.push_back(puncts[$urandom_range(0, 11)]);
        7: begin
          text_bytes.push_back($urandom_range(0, 1) ? "!" : "=");
          if ($urandom_range(0, 1)) text_bytes.push_back("=");
        end
        8, 9: begin
          case ($urandom_range(0, 3))
            0: text_bytes.push_back(" ");
            1: text_bytes.push_back(CH_TAB);
            2: text_bytes.push_back(CH_LF);
            default: text_bytes.push_back(CH_CR);
          endcase
        end
        10: begin
          d = 8'($urandom_range(0, 255));
          text_bytes.push_back(d);
        end
        default: text_bytes.push_back($urandom_range(0, 2) == 0 ? CH_NUL : ".");
      endcase
    end
  endtask

  // Consumer: random stall before each token, then take it
  initial begin : sink
    int stall;
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  task automatic flag_mismatch(string what, logic [39:0] want, logic [39:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %0s: expected %0h, got %0h", what, want, got);
  endtask

  // Compare each token transfer with the oldest expectation
  always @(posedge clk) begin : token_check
    token_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        flag_mismatch("unexpected token", '0, out_tdata);
      end else begin
        want = expected_tokens.pop_front();
        if (out_tdata[4:0] !== want.kind)
          flag_mismatch("kind", 40'(want.kind), 40'(out_tdata[4:0]));
        if (out_tdata[20:5] !== want.start)
          flag_mismatch("start", 40'(want.start), 40'(out_tdata[20:5]));
        if (out_tdata[36:21] !== want.len)
          flag_mismatch("length", 40'(want.len), 40'(out_tdata[36:21]));
        if (out_tlast !== want.last)
          flag_mismatch("last", 40'(want.last), 40'(out_tlast));
      end
    end
  end

  // Abort when neither side has moved a transfer for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    lex_row_t script[$];
    int sent;
    script = '{
      scan_tok("(", TK_LPAREN, 0, 1), scan_tok(")", TK_RPAREN, 1, 1),
      scan_tok("{", TK_LBRACE, 2, 1), scan_tok("}", TK_RBRACE, 3, 1),
      scan_tok(";", TK_SEMI, 4, 1),   scan_tok(",", TK_COMMA, 5, 1),
      scan_tok("+", TK_PLUS, 6, 1),   scan_tok("-", TK_MINUS, 7, 1),
      scan_tok("*", TK_STAR, 8, 1),   scan_tok("/", TK_SLASH, 9, 1),
      scan_tok("<", TK_LT, 10, 1),    scan_tok(">", TK_GT, 11, 1),
      // not-equal, lone bang, equal, lone assign
      scan_only("!", 1'b0),           scan_tok("=", TK_NOTEQ, 12, 2),
      scan_only("!", 1'b0),           scan_tok(CH_CR, TK_BANG, 14, 1),
      scan_only("=", 1'b0),           scan_tok("=", TK_EQ, 16, 2),
      scan_only("=", 1'b0),           scan_tok("_", TK_ASSIGN, 18, 1),
      // identifier cut by a digit, then a float
      scan_tok("9", TK_IDENT, 19, 1), scan_only(".", 1'b0),
      scan_only("5", 1'b0),           scan_tok(" ", TK_FLOAT, 20, 3),
      // two dots make the number illegal; top byte is illegal too
      scan_only("7", 1'b0),           scan_only(".", 1'b0),
      scan_only(".", 1'b0),           scan_only(8'hFF, 1'b0),
      scan_tok(".", TK_ILLEGAL, 28, 1), scan_only(CH_TAB, 1'b0),
      // NUL flushes and ends the text; later bytes drop until the marker
      scan_only("q", 1'b0),           scan_only(CH_NUL, 1'b0),
      scan_only("(", 1'b0),           scan_only(8'h80, 1'b1),
      scan_only("A", 1'b1)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      feed_byte(script[i].chr, script[i].eot, script[i].has_tok, script[i].tok);
    drain_tokens();

    // Random texts, with idle-free stretches and occasional full drains
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      compose_text();
      foreach (text_bytes[i])
        feed_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, '0);
      sent += text_bytes.size();
      if ($urandom_range(0, 3) == 0) drain_tokens();
    end
    no_idle = 1'b0;

    drain_tokens();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* source_byte_tokenizer.f */
rtl/stok_pkg.sv
rtl/stok_front.sv
rtl/stok_queue.sv
rtl/stok_back.sv
rtl/source_byte_tokenizer.sv
test/tb_top.sv
